/* sv/pair_force_periodic_core_defines.svh */
// ----------------------------------------------------------------------------
// Pair force core assertion macros
// Shared concurrent assertion shorthands for the pair force core.
// ----------------------------------------------------------------------------
`ifndef PAIR_FORCE_PERIODIC_CORE_DEFINES_SVH
`define PAIR_FORCE_PERIODIC_CORE_DEFINES_SVH

// Same-cycle implication under active-low reset
`define PFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under active-low reset
`define PFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pfp_pkg.sv */
// ----------------------------------------------------------------------------
// Pair force package
// Register indexes and result status codes of the pair force core.
// ----------------------------------------------------------------------------
`default_nettype none

package pfp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int STATUS_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EQUIL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADHESION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPULSE  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_APPLIED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COIN_ZERO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COIN_ERR  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_CFG   = 3'd4;

endpackage

`default_nettype wire

/* sv/pfp_cfg_if.sv */
// ----------------------------------------------------------------------------
// Pair force configuration channel
// Register write request: index and data under valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfp_cfg_if #(
  parameter int DATA_W = 27
);
  logic                           valid;
  logic                           ready;
  logic [pfp_pkg::CFG_IDX_W-1:0]  index;
  logic [DATA_W-1:0]              data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/pfp_in_if.sv */
// ----------------------------------------------------------------------------
// Pair force input channel
// One particle pair request: two 2D positions under valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfp_in_if #(
  parameter int POS_BITS = 26
);
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] first_x;
  logic [POS_BITS-1:0] first_y;
  logic [POS_BITS-1:0] second_x;
  logic [POS_BITS-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

`default_nettype wire

/* sv/pfp_out_if.sv */
// ----------------------------------------------------------------------------
// Pair force result channel
// Force vector, signed magnitude and status under valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfp_out_if #(
  parameter int OUT_W = 25
);
  logic                          valid;
  logic                          ready;
  logic signed [OUT_W-1:0]       force_x;
  logic signed [OUT_W-1:0]       force_y;
  logic signed [OUT_W-1:0]       force_magnitude;
  logic [pfp_pkg::STATUS_W-1:0]  status;

  modport source (output valid, force_x, force_y, force_magnitude, status, input ready);
  modport sink   (input valid, force_x, force_y, force_magnitude, status, output ready);
endinterface

`default_nettype wire

/* sv/pair_force_periodic_core.sv */
// Path from request to result: raw separation, minimum-image wrap, squares,
// their sum, the bit-per-stage square root, distance classification and
// the two bit-per-stage dividers (magnitude, then both force components).
// Throughput: one request per cycle; the whole pipe stalls only when the
// result register is full and not taken.
// Reset: clears all stage valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
// Pair force core
// Minimum-image separation, distance and piecewise linear pair force.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pair_force_periodic_core_defines.svh"

module pair_force_periodic_core import pfp_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int POS_BITS  = 26
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pfp_cfg_if.sink    cfg_i,
  pfp_in_if.sink     in_i,
  pfp_out_if.source  out_o
);

  localparam int P   = POS_BITS;
  localparam int S   = FRAC_BITS + 8;   // strength width, quotient bits
  localparam int OW  = S + 1;           // signed result width
  localparam int R   = P + 1;           // square root result bits
  localparam int SQW = 2 * P + 2;       // square root remainder width
  localparam int NW  = S + P;           // dividend width

  localparam logic [P-1:0] RST_CUT   = P'(5 << (FRAC_BITS - 1));
  localparam logic [P-1:0] RST_REQ   = P'(1 << FRAC_BITS);
  localparam logic [P:0]   RST_BOX   = (P + 1)'(10 << FRAC_BITS);
  localparam logic [S-1:0] RST_STR   = S'(1 << FRAC_BITS);

  typedef struct packed {
    logic         sx;
    logic         sy;
    logic [P-1:0] mx;
    logic [P-1:0] my;
  } side_t;

  typedef struct packed {
    logic [SQW-1:0] rem;
    logic [R-1:0]   root;
    side_t          sb;
  } sqrt_t;

  typedef struct packed {
    logic [NW-1:0]       rem;
    logic [S-1:0]        quo;
    logic [P-1:0]        den;
    logic [STATUS_W-1:0] status;
    logic                neg;
    logic [P-1:0]        dlen;
    side_t               sb;
  } mdiv_t;

  typedef struct packed {
    logic [NW-1:0]       remx;
    logic [NW-1:0]       remy;
    logic [S-1:0]        qx;
    logic [S-1:0]        qy;
    logic [P-1:0]        den;
    logic [S-1:0]        mag;
    logic [STATUS_W-1:0] status;
    logic                neg;
    logic                sx;
    logic                sy;
  } fdiv_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                neg;
    logic [P-1:0]        diff;
    logic [S-1:0]        str;
    logic [P-1:0]        den;
    logic [P-1:0]        dlen;
    side_t               sb;
  } eval_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [P-1:0] cut_q, req_q;
  logic [P:0]   box_q;
  logic [S-1:0] adh_q, rep_q;

  assign cfg_i.ready = 1'b1;

  // Load register on a write request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= RST_CUT;
      req_q <= RST_REQ;
      box_q <= RST_BOX;
      adh_q <= RST_STR;
      rep_q <= RST_STR;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_CUTOFF:   cut_q <= cfg_i.data[P-1:0];
        REG_EQUIL:    req_q <= cfg_i.data[P-1:0];
        REG_BOX:      box_q <= cfg_i.data[P:0];
        REG_ADHESION: adh_q <= cfg_i.data[S-1:0];
        REG_REPULSE:  rep_q <= cfg_i.data[S-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together
  // --------------------------------------------------------------------------
  logic en;
  logic out_v_q;

  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // --------------------------------------------------------------------------
  // Stage A: raw separation
  // --------------------------------------------------------------------------
  logic              va_q;
  logic signed [P:0] ax_q, ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en) va_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= $signed({1'b0, in_i.second_x}) - $signed({1'b0, in_i.first_x});
      ay_q <= $signed({1'b0, in_i.second_y}) - $signed({1'b0, in_i.first_y});
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: minimum image wrap, split into sign and magnitude
  // --------------------------------------------------------------------------
  function automatic logic signed [P:0] wrap_axis(input logic signed [P:0] d,
                                                  input logic [P:0] box);
    logic signed [P+2:0] wd0, wd1, wd2, wbox;
    wbox = $signed({2'b00, box});
    wd0  = {{2{d[P]}}, d};
    wd1  = ((wd0 <<< 1) > wbox) ? wd0 - wbox : wd0;
    wd2  = ((wd1 <<< 1) <= -wbox) ? wd1 + wbox : wd1;
    return wd2[P:0];
  endfunction

  function automatic logic [P-1:0] abs_p(input logic signed [P:0] d);
    logic signed [P:0] a;
    a = d[P] ? -d : d;
    return a[P-1:0];
  endfunction

  logic              vb_q;
  side_t             b_q;
  logic signed [P:0] wx, wy;

  assign wx = wrap_axis(ax_q, box_q);
  assign wy = wrap_axis(ay_q, box_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en) vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q.sx <= wx[P];
      b_q.sy <= wy[P];
      b_q.mx <= abs_p(wx);
      b_q.my <= abs_p(wy);
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: squares
  // --------------------------------------------------------------------------
  logic           vc_q;
  side_t          c_sb_q;
  logic [2*P-1:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en) vc_q <= vb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_sb_q <= b_q;
      sqx_q  <= b_q.mx * b_q.mx;
      sqy_q  <= b_q.my * b_q.my;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D and square root: sum of squares, then one root bit per stage
  // --------------------------------------------------------------------------
  logic  vsq_q [0:R];
  sqrt_t sq_q  [0:R];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vsq_q[0] <= 1'b0;
    else if (en) vsq_q[0] <= vc_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].rem  <= SQW'(sqx_q) + SQW'(sqy_q);
      sq_q[0].root <= '0;
      sq_q[0].sb   <= c_sb_q;
    end
  end

  for (genvar j = 0; j < R; j++) begin : g_sqrt
    localparam int K = R - 1 - j;
    logic [SQW-1:0] trial;
    logic           take;

    assign trial = (SQW'(sq_q[j].root) << (K + 1)) | (SQW'(1) << (2 * K));
    assign take  = sq_q[j].rem >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vsq_q[j+1] <= 1'b0;
      else if (en) vsq_q[j+1] <= vsq_q[j];
    end

    // Try this root bit; keep it when the remainder covers it
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[j+1].sb   <= sq_q[j].sb;
        sq_q[j+1].rem  <= take ? sq_q[j].rem - trial : sq_q[j].rem;
        sq_q[j+1].root <= take ? (sq_q[j].root | (R'(1) << K)) : sq_q[j].root;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: classify distance, pick force branch
  // --------------------------------------------------------------------------
  logic                ve_q;
  eval_t               e_q;
  logic [R-1:0]        dlen;
  logic                bad_cfg, beyond, repel;
  logic [STATUS_W-1:0] status_d;

  assign dlen    = sq_q[R].root;
  assign bad_cfg = (cut_q <= req_q) || (req_q == '0) || (box_q == '0);
  assign beyond  = dlen > {1'b0, cut_q};
  assign repel   = dlen < {1'b0, req_q};

  always_comb begin
    if (bad_cfg) begin
      status_d = ST_BAD_CFG;
    end else if (dlen == '0) begin
      status_d = (rep_q != '0) ? ST_COIN_ERR : ST_COIN_ZERO;
    end else if (beyond) begin
      status_d = ST_BEYOND;
    end else begin
      status_d = ST_APPLIED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else if (en) ve_q <= vsq_q[R];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q.status <= status_d;
      e_q.neg    <= dlen > {1'b0, req_q};
      e_q.diff   <= repel ? req_q - dlen[P-1:0] : dlen[P-1:0] - req_q;
      e_q.str    <= repel ? rep_q : adh_q;
      e_q.den    <= repel ? req_q : cut_q - req_q;
      e_q.dlen   <= dlen[P-1:0];
      e_q.sb     <= sq_q[R].sb;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F and magnitude divider: strength times offset, then one bit a stage
  // --------------------------------------------------------------------------
  logic  vmd_q [0:S];
  mdiv_t md_q  [0:S];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vmd_q[0] <= 1'b0;
    else if (en) vmd_q[0] <= ve_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0].rem    <= e_q.str * e_q.diff;
      md_q[0].quo    <= '0;
      md_q[0].den    <= e_q.den;
      md_q[0].status <= e_q.status;
      md_q[0].neg    <= e_q.neg;
      md_q[0].dlen   <= e_q.dlen;
      md_q[0].sb     <= e_q.sb;
    end
  end

  for (genvar j = 0; j < S; j++) begin : g_mdiv
    localparam int K = S - 1 - j;
    logic [NW-1:0] trial;
    logic          take;

    assign trial = NW'(md_q[j].den) << K;
    assign take  = md_q[j].rem >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vmd_q[j+1] <= 1'b0;
      else if (en) vmd_q[j+1] <= vmd_q[j];
    end

    // Subtract the shifted divisor when it fits
    always_ff @(posedge clk_i) begin
      if (en) begin
        md_q[j+1].rem    <= take ? md_q[j].rem - trial : md_q[j].rem;
        md_q[j+1].quo    <= take ? (md_q[j].quo | (S'(1) << K)) : md_q[j].quo;
        md_q[j+1].den    <= md_q[j].den;
        md_q[j+1].status <= md_q[j].status;
        md_q[j+1].neg    <= md_q[j].neg;
        md_q[j+1].dlen   <= md_q[j].dlen;
        md_q[j+1].sb     <= md_q[j].sb;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage G and component dividers: |d| times magnitude over distance
  // --------------------------------------------------------------------------
  logic  vfd_q [0:S];
  fdiv_t fd_q  [0:S];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vfd_q[0] <= 1'b0;
    else if (en) vfd_q[0] <= vmd_q[S];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fd_q[0].remx   <= md_q[S].sb.mx * md_q[S].quo;
      fd_q[0].remy   <= md_q[S].sb.my * md_q[S].quo;
      fd_q[0].qx     <= '0;
      fd_q[0].qy     <= '0;
      fd_q[0].den    <= md_q[S].dlen;
      fd_q[0].mag    <= md_q[S].quo;
      fd_q[0].status <= md_q[S].status;
      fd_q[0].neg    <= md_q[S].neg;
      fd_q[0].sx     <= md_q[S].sb.sx;
      fd_q[0].sy     <= md_q[S].sb.sy;
    end
  end

  for (genvar j = 0; j < S; j++) begin : g_fdiv
    localparam int K = S - 1 - j;
    logic [NW-1:0] trial;
    logic          take_x, take_y;

    assign trial  = NW'(fd_q[j].den) << K;
    assign take_x = fd_q[j].remx >= trial;
    assign take_y = fd_q[j].remy >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vfd_q[j+1] <= 1'b0;
      else if (en) vfd_q[j+1] <= vfd_q[j];
    end

    // Advance both lanes against the shared divisor
    always_ff @(posedge clk_i) begin
      if (en) begin
        fd_q[j+1].remx   <= take_x ? fd_q[j].remx - trial : fd_q[j].remx;
        fd_q[j+1].remy   <= take_y ? fd_q[j].remy - trial : fd_q[j].remy;
        fd_q[j+1].qx     <= take_x ? (fd_q[j].qx | (S'(1) << K)) : fd_q[j].qx;
        fd_q[j+1].qy     <= take_y ? (fd_q[j].qy | (S'(1) << K)) : fd_q[j].qy;
        fd_q[j+1].den    <= fd_q[j].den;
        fd_q[j+1].mag    <= fd_q[j].mag;
        fd_q[j+1].status <= fd_q[j].status;
        fd_q[j+1].neg    <= fd_q[j].neg;
        fd_q[j+1].sx     <= fd_q[j].sx;
        fd_q[j+1].sy     <= fd_q[j].sy;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: apply signs, zero the force outputs off the applied path
  // --------------------------------------------------------------------------
  logic signed [OW-1:0] out_fx_q, out_fy_q, out_fm_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic signed [OW-1:0] fx_u, fy_u, fm_u;
  logic                 applied;

  assign applied = fd_q[S].status == ST_APPLIED;
  assign fx_u    = $signed({1'b0, fd_q[S].qx});
  assign fy_u    = $signed({1'b0, fd_q[S].qy});
  assign fm_u    = $signed({1'b0, fd_q[S].mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= vfd_q[S];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_status_q <= fd_q[S].status;
      out_fx_q     <= !applied ? '0 : ((fd_q[S].sx ^ fd_q[S].neg) ? -fx_u : fx_u);
      out_fy_q     <= !applied ? '0 : ((fd_q[S].sy ^ fd_q[S].neg) ? -fy_u : fy_u);
      out_fm_q     <= !applied ? '0 : (fd_q[S].neg ? -fm_u : fm_u);
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.force_x         = out_fx_q;
  assign out_o.force_y         = out_fy_q;
  assign out_o.force_magnitude = out_fm_q;
  assign out_o.status          = out_status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PFP_ASSERT_IMPL(a_zero_unless_applied, clk_i, rst_ni,
    out_v_q && (out_status_q != ST_APPLIED),
    (out_fx_q == '0) && (out_fy_q == '0) && (out_fm_q == '0),
    "force nonzero on a result that was not applied")

  `PFP_ASSERT_IMPL(a_zero_mag_zero_vec, clk_i, rst_ni,
    out_v_q && (out_fm_q == '0),
    (out_fx_q == '0) && (out_fy_q == '0),
    "force vector nonzero with zero magnitude")

  `PFP_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni,
    in_i.valid && in_i.ready, va_q,
    "accepted request did not enter the first stage")

  `PFP_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni,
    !en, $stable(va_q) && $stable(ve_q) && $stable(out_v_q) && $stable(vsq_q[R]),
    "pipeline moved while stalled")

endmodule

`default_nettype wire
